@@ rtl/ttcd_pkg.sv @@
// shared constants, types and tables for the timestamp to civil date converter
`default_nettype none

package ttcd_pkg;

    localparam int STAMP_BITS_DEF = 40;
    localparam int DIGIT_W        = 4;

    localparam int SECS_PER_DAY   = 86400;
    localparam int SECS_PER_HOUR  = 3600;
    localparam int SECS_PER_MIN   = 60;
    localparam int DAYS_PER_ERA   = 146097;
    localparam int DAYS_PER_YEAR  = 365;
    localparam int YEARS_PER_ERA  = 400;
    localparam int YEAR_BASE      = 1900;
    localparam int MP_JANUARY     = 10;
    localparam int MP_TO_MONTH    = 2;

    localparam int OFFSET_W                  = 20;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 20'd730425;

    localparam int TOD_W  = 17;
    localparam int DOE_W  = 18;
    localparam int YEAR_W = 16;

    localparam int ERA_DIV_STAGES_DEF = (STAMP_BITS_DEF - 10 + DIGIT_W - 1) / DIGIT_W;

    // reciprocal multipliers, exact for the operand widths used
    localparam int R1460_SH  = 29;
    localparam int R1460_MUL = ((1 << R1460_SH) + 1460 - 1) / 1460;
    localparam int R365_SH   = 27;
    localparam int R365_MUL  = ((1 << R365_SH) + DAYS_PER_YEAR - 1) / DAYS_PER_YEAR;
    localparam int R153_SH   = 19;
    localparam int R153_MUL  = ((1 << R153_SH) + 153 - 1) / 153;
    localparam int R3600_SH  = 29;
    localparam int R3600_MUL = ((1 << R3600_SH) + SECS_PER_HOUR - 1) / SECS_PER_HOUR;
    localparam int R60_SH    = 18;
    localparam int R60_MUL   = ((1 << R60_SH) + SECS_PER_MIN - 1) / SECS_PER_MIN;

    localparam int CENTURY_DAYS = 36524;
    localparam int YEARS_PER_CENTURY = 100;

    typedef struct packed {
        logic signed [YEAR_W-1:0] year_since_1900;
        logic [3:0]               month_index;
        logic [4:0]               day_of_month;
        logic [4:0]               hour_of_day;
        logic [5:0]               minute_of_hour;
        logic [5:0]               second_of_minute;
    } t_result;

    // days from march 1 to the first of the march-based month
    function automatic logic [8:0] days_before_month(input logic [3:0] mp);
        logic [8:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ttcd_divider.sv @@
// pipelined radix-16 long division of an unsigned value by a constant
`default_nettype none

module ttcd_divider #(
    parameter int DW      = ttcd_pkg::STAMP_BITS_DEF + 1,
    parameter int DIVISOR = ttcd_pkg::SECS_PER_DAY,
    localparam int RW     = $clog2(DIVISOR)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [DW-1:0] i_num,
    output logic               o_valid,
    output logic [DW-1:0]      o_quo,
    output logic [RW-1:0]      o_rem
);

    localparam int DGW = ttcd_pkg::DIGIT_W;
    localparam int ND  = (DW + DGW - 1) / DGW;
    localparam int PW  = ND * DGW;
    localparam int XW  = RW + DGW;

    logic [ND-1:0]  r_vld;
    logic [PW-1:0]  r_num [ND];
    logic [PW-1:0]  r_quo [ND];
    logic [RW-1:0]  r_rem [ND];

    logic [ND-1:0]  c_vld;
    logic [PW-1:0]  c_num  [ND];
    logic [PW-1:0]  c_quo  [ND];
    logic [RW-1:0]  c_rem  [ND];
    logic [XW-1:0]  c_part [ND];
    logic [XW-1:0]  c_sub  [ND];
    logic [DGW-1:0] c_dig  [ND];

    always_comb begin
        c_num[0] = PW'(i_num);
        c_quo[0] = '0;
        c_rem[0] = '0;
        c_vld[0] = i_valid;
        for (int k = 1; k < ND; k++) begin
            c_num[k] = r_num[k-1];
            c_quo[k] = r_quo[k-1];
            c_rem[k] = r_rem[k-1];
            c_vld[k] = r_vld[k-1];
        end
        for (int k = 0; k < ND; k++) begin
            c_part[k] = {c_rem[k], c_num[k][PW-1-DGW*k -: DGW]};
            c_dig[k]  = '0;
            c_sub[k]  = '0;
            for (int j = 1; j < (1 << DGW); j++) begin
                if (c_part[k] >= XW'(j * DIVISOR)) begin
                    c_dig[k] = DGW'(j);
                    c_sub[k] = XW'(j * DIVISOR);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ND; k++) begin
                r_num[k] <= c_num[k];
                r_quo[k] <= {c_quo[k][PW-DGW-1:0], c_dig[k]};
                r_rem[k] <= RW'(c_part[k] - c_sub[k]);
            end
        end
    end

    assign o_valid = r_vld[ND-1];
    assign o_quo   = DW'(r_quo[ND-1]);
    assign o_rem   = r_rem[ND-1];

endmodule

`default_nettype wire

@@ rtl/ttcd_delay.sv @@
// enabled shift line that keeps side data aligned with a pipeline
`default_nettype none

module ttcd_delay #(
    parameter int W     = ttcd_pkg::TOD_W,
    parameter int DEPTH = ttcd_pkg::ERA_DIV_STAGES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_d,
    output logic [W-1:0]      o_d
);

    logic [W-1:0] r_taps [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_taps[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_taps[k] <= r_taps[k-1];
            end
        end
    end

    assign o_d = r_taps[DEPTH-1];

endmodule

`default_nettype wire

@@ rtl/ttcd_calendar.sv @@
// five-stage conversion of era, day of era and second of day to date and time
`default_nettype none

module ttcd_calendar (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [ttcd_pkg::YEAR_W-1:0]   i_era,
    input  wire logic [ttcd_pkg::DOE_W-1:0]    i_doe,
    input  wire logic [ttcd_pkg::TOD_W-1:0]    i_tod,
    output logic                               o_valid,
    output ttcd_pkg::t_result                  o_res
);

    localparam int DW  = ttcd_pkg::DOE_W;
    localparam int TW  = ttcd_pkg::TOD_W;
    localparam int YW  = ttcd_pkg::YEAR_W;
    localparam int PA_W = DW + 19;
    localparam int PY_W = DW + 19;
    localparam int PH_W = TW + 18;
    localparam int PM_W = 12 + 13;
    localparam int PP_W = 11 + 12;

    // stage 1
    logic [PA_W-1:0] c1_pa;
    logic [PH_W-1:0] c1_ph;
    logic [6:0]      c1_a;
    logic [2:0]      c1_b;
    logic            c1_c;
    logic            r1_vld;
    logic [YW-1:0]   r1_era;
    logic [DW-1:0]   r1_doe;
    logic [6:0]      r1_a;
    logic [2:0]      r1_b;
    logic            r1_c;
    logic [TW-1:0]   r1_tod;
    logic [4:0]      r1_hour;

    assign c1_pa = PA_W'(i_doe) * PA_W'(ttcd_pkg::R1460_MUL);
    assign c1_ph = PH_W'(i_tod) * PH_W'(ttcd_pkg::R3600_MUL);
    assign c1_a  = 7'(c1_pa >> ttcd_pkg::R1460_SH);
    assign c1_b  = 3'(i_doe >= DW'(ttcd_pkg::CENTURY_DAYS))
                 + 3'(i_doe >= DW'(2 * ttcd_pkg::CENTURY_DAYS))
                 + 3'(i_doe >= DW'(3 * ttcd_pkg::CENTURY_DAYS))
                 + 3'(i_doe >= DW'(4 * ttcd_pkg::CENTURY_DAYS));
    assign c1_c  = (i_doe == DW'(ttcd_pkg::DAYS_PER_ERA - 1));

    // stage 2
    logic [DW-1:0]   c2_x;
    logic [PY_W-1:0] c2_py;
    logic [8:0]      c2_yoe;
    logic [11:0]     c2_mh;
    logic            r2_vld;
    logic [YW-1:0]   r2_era;
    logic [DW-1:0]   r2_doe;
    logic [8:0]      r2_yoe;
    logic [4:0]      r2_hour;
    logic [11:0]     r2_mh;

    assign c2_x   = r1_doe - DW'(r1_a) + DW'(r1_b) - DW'(r1_c);
    assign c2_py  = PY_W'(c2_x) * PY_W'(ttcd_pkg::R365_MUL);
    assign c2_yoe = 9'(c2_py >> ttcd_pkg::R365_SH);
    assign c2_mh  = 12'(r1_tod - TW'(ttcd_pkg::SECS_PER_HOUR) * TW'(r1_hour));

    // stage 3
    logic [1:0]      c3_cent;
    logic [8:0]      c3_doy;
    logic [PM_W-1:0] c3_pm;
    logic [5:0]      c3_min;
    logic            r3_vld;
    logic [YW-1:0]   r3_era;
    logic [8:0]      r3_yoe;
    logic [8:0]      r3_doy;
    logic [4:0]      r3_hour;
    logic [11:0]     r3_mh;
    logic [5:0]      r3_min;

    assign c3_cent = 2'(r2_yoe >= 9'(ttcd_pkg::YEARS_PER_CENTURY))
                   + 2'(r2_yoe >= 9'(2 * ttcd_pkg::YEARS_PER_CENTURY))
                   + 2'(r2_yoe >= 9'(3 * ttcd_pkg::YEARS_PER_CENTURY));
    assign c3_doy  = 9'(r2_doe - (DW'(ttcd_pkg::DAYS_PER_YEAR) * DW'(r2_yoe)
                     + DW'(r2_yoe >> 2) - DW'(c3_cent)));
    assign c3_pm   = PM_W'(r2_mh) * PM_W'(ttcd_pkg::R60_MUL);
    assign c3_min  = 6'(c3_pm >> ttcd_pkg::R60_SH);

    // stage 4
    logic [10:0]     c4_t;
    logic [PP_W-1:0] c4_pp;
    logic [3:0]      c4_mp;
    logic [5:0]      c4_sec;
    logic            r4_vld;
    logic [YW-1:0]   r4_era;
    logic [8:0]      r4_yoe;
    logic [8:0]      r4_doy;
    logic [3:0]      r4_mp;
    logic [4:0]      r4_hour;
    logic [5:0]      r4_min;
    logic [5:0]      r4_sec;

    assign c4_t   = 11'(5) * 11'(r3_doy) + 11'(2);
    assign c4_pp  = PP_W'(c4_t) * PP_W'(ttcd_pkg::R153_MUL);
    assign c4_mp  = 4'(c4_pp >> ttcd_pkg::R153_SH);
    assign c4_sec = 6'(r3_mh - 12'(ttcd_pkg::SECS_PER_MIN) * 12'(r3_min));

    // stage 5
    logic              c5_late;
    ttcd_pkg::t_result c5_res;
    logic              r5_vld;
    ttcd_pkg::t_result r5_res;

    always_comb begin
        c5_late = (r4_mp >= 4'(ttcd_pkg::MP_JANUARY));
        c5_res.day_of_month = 5'(r4_doy - ttcd_pkg::days_before_month(r4_mp) + 9'd1);
        c5_res.month_index  = c5_late ? r4_mp - 4'(ttcd_pkg::MP_JANUARY)
                                      : r4_mp + 4'(ttcd_pkg::MP_TO_MONTH);
        c5_res.year_since_1900 = r4_era * YW'(ttcd_pkg::YEARS_PER_ERA) + YW'(r4_yoe)
                               + YW'(c5_late) - YW'(ttcd_pkg::YEAR_BASE);
        c5_res.hour_of_day      = r4_hour;
        c5_res.minute_of_hour   = r4_min;
        c5_res.second_of_minute = r4_sec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_era  <= i_era;
            r1_doe  <= i_doe;
            r1_a    <= c1_a;
            r1_b    <= c1_b;
            r1_c    <= c1_c;
            r1_tod  <= i_tod;
            r1_hour <= 5'(c1_ph >> ttcd_pkg::R3600_SH);

            r2_era  <= r1_era;
            r2_doe  <= r1_doe;
            r2_yoe  <= c2_yoe;
            r2_hour <= r1_hour;
            r2_mh   <= c2_mh;

            r3_era  <= r2_era;
            r3_yoe  <= r2_yoe;
            r3_doy  <= c3_doy;
            r3_hour <= r2_hour;
            r3_mh   <= r2_mh;
            r3_min  <= c3_min;

            r4_era  <= r3_era;
            r4_yoe  <= r3_yoe;
            r4_doy  <= r3_doy;
            r4_mp   <= c4_mp;
            r4_hour <= r3_hour;
            r4_min  <= r3_min;
            r4_sec  <= c4_sec;

            r5_res  <= c5_res;
        end
    end

    assign o_valid = r5_vld;
    assign o_res   = r5_res;

endmodule

`default_nettype wire

@@ rtl/timestamp_to_civil_datetime.sv @@
// top level: signed epoch seconds to gregorian utc date and time of day
//
// channel   dir  transfer on            payload
// in        in   i_valid & o_ready      i_seconds_since_epoch
// out       out  o_valid & i_ready      o_year_since_1900 .. o_second_of_minute
// cfg       in   i_cfg_we               i_cfg_wdata (epoch day offset)
//
// one transfer per cycle in and out while o_ready and i_ready stay high; a result passes
// the input register, day divider, a register, era divider, calendar stages and output register
// reset clears all valid bits and loads the offset register with its default
// a single global enable moves the whole pipeline; a skid register behind the output
// register takes the next result during an output stall, and o_ready drops only when it is full
`default_nettype none

module timestamp_to_civil_datetime #(
    parameter int STAMP_BITS = ttcd_pkg::STAMP_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ttcd_pkg::OFFSET_W-1:0]     i_cfg_wdata,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [STAMP_BITS-1:0]      i_seconds_since_epoch,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [ttcd_pkg::YEAR_W-1:0]     o_year_since_1900,
    output logic [3:0]                             o_month_index,
    output logic [4:0]                             o_day_of_month,
    output logic [4:0]                             o_hour_of_day,
    output logic [5:0]                             o_minute_of_hour,
    output logic [5:0]                             o_second_of_minute
);

    localparam int DW1 = STAMP_BITS + 1;
    localparam int ZW  = STAMP_BITS - 11;
    localparam int DW2 = ZW + 1;
    localparam int ERA_STAGES = (DW2 + ttcd_pkg::DIGIT_W - 1) / ttcd_pkg::DIGIT_W;

    localparam logic [DW1-1:0] DAY_HALF = DW1'(1) << (STAMP_BITS - 1);
    localparam logic [DW1-1:0] DAY_K    = (DAY_HALF + DW1'(ttcd_pkg::SECS_PER_DAY - 1))
                                          / DW1'(ttcd_pkg::SECS_PER_DAY);
    localparam logic [DW1-1:0] DAY_BIAS = DAY_K * DW1'(ttcd_pkg::SECS_PER_DAY);
    localparam logic [DW2-1:0] ERA_HALF = DW2'(1) << (ZW - 1);
    localparam logic [DW2-1:0] ERA_K    = (ERA_HALF + DW2'(ttcd_pkg::DAYS_PER_ERA - 1))
                                          / DW2'(ttcd_pkg::DAYS_PER_ERA);
    localparam logic [DW2-1:0] ERA_BIAS = ERA_K * DW2'(ttcd_pkg::DAYS_PER_ERA);
    localparam logic [DW2-1:0] Z_BIAS   = ERA_BIAS - DW2'(DAY_K);

    logic                            w_en;
    logic [ttcd_pkg::OFFSET_W-1:0]   r_offset;

    logic                            r0_vld;
    logic [DW1-1:0]                  r0_u;

    logic                            d1_vld;
    logic [DW1-1:0]                  d1_quo;
    logic [ttcd_pkg::TOD_W-1:0]      d1_rem;

    logic                            r1_vld;
    logic [DW2-1:0]                  r1_z;
    logic [ttcd_pkg::TOD_W-1:0]      r1_tod;

    logic                            d2_vld;
    logic [DW2-1:0]                  d2_quo;
    logic [ttcd_pkg::DOE_W-1:0]      d2_rem;
    logic [ttcd_pkg::TOD_W-1:0]      w_tod;
    logic [ttcd_pkg::YEAR_W-1:0]     w_era;

    logic                            cal_vld;
    ttcd_pkg::t_result               cal_res;

    logic                            r_out_vld;
    logic                            r_skid_vld;
    ttcd_pkg::t_result               r_out;
    ttcd_pkg::t_result               r_skid;

    assign w_en    = !r_skid_vld;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= ttcd_pkg::OFFSET_RESET;
        end else if (i_cfg_we) begin
            r_offset <= i_cfg_wdata;
        end
    end

    // bias the stamp so the floor division runs on a non-negative value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r0_vld <= i_valid;
            r1_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_u   <= {i_seconds_since_epoch[STAMP_BITS-1], i_seconds_since_epoch} + DAY_BIAS;
            r1_z   <= DW2'(d1_quo) + DW2'(r_offset) + Z_BIAS;
            r1_tod <= d1_rem;
        end
    end

    ttcd_divider #(
        .DW      (DW1),
        .DIVISOR (ttcd_pkg::SECS_PER_DAY)
    ) u_day_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r0_vld),
        .i_num   (r0_u),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_rem   (d1_rem)
    );

    ttcd_divider #(
        .DW      (DW2),
        .DIVISOR (ttcd_pkg::DAYS_PER_ERA)
    ) u_era_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_vld),
        .i_num   (r1_z),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_rem   (d2_rem)
    );

    ttcd_delay #(
        .W     (ttcd_pkg::TOD_W),
        .DEPTH (ERA_STAGES)
    ) u_tod_delay (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r1_tod),
        .o_d   (w_tod)
    );

    assign w_era = ttcd_pkg::YEAR_W'(d2_quo) - ttcd_pkg::YEAR_W'(ERA_K);

    ttcd_calendar u_calendar (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (d2_vld),
        .i_era   (w_era),
        .i_doe   (d2_rem),
        .i_tod   (w_tod),
        .o_valid (cal_vld),
        .o_res   (cal_res)
    );

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_skid_vld) begin
            if (cal_vld) begin
                if (!r_out_vld || i_ready) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end else if (i_ready) begin
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            if (cal_vld && (!r_out_vld || i_ready)) begin
                r_out <= cal_res;
            end
            if (cal_vld && r_out_vld && !i_ready) begin
                r_skid <= cal_res;
            end
        end else if (i_ready) begin
            r_out <= r_skid;
        end
    end

    assign o_valid            = r_out_vld;
    assign o_year_since_1900  = r_out.year_since_1900;
    assign o_month_index      = r_out.month_index;
    assign o_day_of_month     = r_out.day_of_month;
    assign o_hour_of_day      = r_out.hour_of_day;
    assign o_minute_of_hour   = r_out.minute_of_hour;
    assign o_second_of_minute = r_out.second_of_minute;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a result while the output register is empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_ready) |=> r_skid_vld)
        else $error("skid result lost during output stall");

    a_blocked_result_caught: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cal_vld && r_out_vld && !i_ready && !r_skid_vld) |=> r_skid_vld)
        else $error("pipeline result dropped at blocked output");

endmodule

`default_nettype wire
